FILE: src/gcd_pkg.sv
`default_nettype none

package gcd_pkg;

	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned WDAY_W  = 3;
	localparam int unsigned ORD_W   = 9;
	localparam int unsigned DELTA_W = 16;
	localparam int unsigned WD_W    = DELTA_W + 1;

	localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1;
	localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
	localparam logic [YEAR_W-1:0]  YEAR_RESET = 14'd1970;
	localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
	localparam logic [DAY_W-1:0]   DAY_FIRST  = 5'd1;
	localparam logic [DAY_W-1:0]   DEC_LEN    = 5'd31;

	// floor(x/100) = (x*5243) >> 19, exact for x < 43690
	localparam int unsigned DIV100_MUL   = 5243;
	localparam int unsigned DIV100_SHIFT = 19;
	localparam int unsigned DIV100_Q_W   = 8;
	// floor(x/7) estimate, low by at most one for x < 16384
	localparam int unsigned MOD7_MUL     = 9362;
	localparam int unsigned MOD7_SHIFT   = 16;

	typedef enum logic [1:0] {
		OP_SET  = 2'd0,
		OP_NEXT = 2'd1,
		OP_PREV = 2'd2,
		OP_ADD  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LEAP,
		ST_EXEC,
		ST_ADD,
		ST_ALEAP,
		ST_FIN,
		ST_FLEAP,
		ST_WD1,
		ST_WD2
	} state_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		len = 5'd31;
		if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
			len = 5'd30;
		end else if (m == MONTH_FEB) begin
			len = leap ? 5'd29 : 5'd28;
		end
		return len;
	endfunction

	function automatic logic [ORD_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
		logic [ORD_W-1:0] c;
		case (m)
			4'd2:    c = 9'd31;
			4'd3:    c = 9'd59;
			4'd4:    c = 9'd90;
			4'd5:    c = 9'd120;
			4'd6:    c = 9'd151;
			4'd7:    c = 9'd181;
			4'd8:    c = 9'd212;
			4'd9:    c = 9'd243;
			4'd10:   c = 9'd273;
			4'd11:   c = 9'd304;
			4'd12:   c = 9'd334;
			default: c = 9'd0;
		endcase
		return c;
	endfunction

	// (13*mm + 8) / 5 with Jan/Feb as months 13/14 of the prior year
	function automatic logic [5:0] month_term(input logic [MONTH_W-1:0] m);
		logic [5:0] t;
		case (m)
			4'd1:    t = 6'd35;
			4'd2:    t = 6'd38;
			4'd3:    t = 6'd9;
			4'd4:    t = 6'd12;
			4'd5:    t = 6'd14;
			4'd6:    t = 6'd17;
			4'd7:    t = 6'd19;
			4'd8:    t = 6'd22;
			4'd9:    t = 6'd25;
			4'd10:   t = 6'd27;
			4'd11:   t = 6'd30;
			4'd12:   t = 6'd32;
			default: t = 6'd0;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

FILE: src/gcd_div100.sv
`default_nettype none

module gcd_div100 (
	input  logic [gcd_pkg::YEAR_W-1:0]     dividend,
	output logic [gcd_pkg::DIV100_Q_W-1:0] quotient,
	output logic                           exact
);

	localparam int unsigned PROD_W = gcd_pkg::YEAR_W + 13;

	logic [PROD_W-1:0]          prod;
	logic [gcd_pkg::YEAR_W-1:0] back;

	assign prod     = PROD_W'(dividend) * PROD_W'(gcd_pkg::DIV100_MUL);
	assign quotient = prod[gcd_pkg::DIV100_SHIFT +: gcd_pkg::DIV100_Q_W];
	// q*100 = q*64 + q*32 + q*4
	assign back     = gcd_pkg::YEAR_W'({quotient, 6'b0}) + gcd_pkg::YEAR_W'({quotient, 5'b0})
		+ gcd_pkg::YEAR_W'({quotient, 2'b0});
	assign exact    = (back == dividend);

endmodule

`default_nettype wire

FILE: src/gregorian_calendar_date_unit_top.sv
`default_nettype none

// channel  dir  handshake          payload
// s        in   s_tvalid/s_tready  s_tdata (date, delta), s_tuser (operation)
// m        out  m_tvalid/m_tready  m_tdata (date, weekday, ordinal), m_tuser (error)
//
// Set, next and previous pass through LEAP, EXEC, FIN, FLEAP, WD1 and WD2 to the result.
// Add also walks one month per ADD step and takes an ALEAP step per year crossed, the
// month walk on the shared day adder.
// s_tready is high only while no transaction is in work.
// A result waiting on m_tready does not block acceptance; the next result holds
// in the final stage until the output register is free.
// arst_n loads 1970-01-01; no clearing pass.
module gregorian_calendar_date_unit_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // new_year[13:0], new_month[17:14], new_day[22:18],
	                              // day_delta[38:23], zero[39]
	input  logic [1:0]  s_tuser,  // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // cur_year[13:0], cur_month[17:14], cur_day[22:18],
	                              // weekday[25:23], ordinal_day[34:26], zero[39:35]
	output logic [0:0]  m_tuser   // range_error[0]
);

	localparam int unsigned YW = gcd_pkg::YEAR_W;
	localparam int unsigned MW = gcd_pkg::MONTH_W;
	localparam int unsigned DW = gcd_pkg::DAY_W;
	localparam int unsigned WW = gcd_pkg::WD_W;
	localparam int unsigned QW = gcd_pkg::DIV100_Q_W;
	localparam int unsigned SW = YW;
	localparam int unsigned PW = 2 * SW;

	gcd_pkg::state_t state_q, state_d;

	logic [YW-1:0] year_q;
	logic [MW-1:0] month_q;
	logic [DW-1:0] day_q;

	gcd_pkg::op_t                        op_q;
	logic [DW-1:0]                       nd_q;
	logic signed [gcd_pkg::DELTA_W-1:0]  delta_q;
	logic [YW-1:0]                       wy_q;
	logic [MW-1:0]                       wm_q;
	logic signed [WW-1:0]                wd_q;
	logic                                err_q;
	logic                                leap_q;
	logic [SW-1:0]                       sum_q;
	logic [gcd_pkg::ORD_W-1:0]           ord_q;

	logic                        ovalid_q;
	logic [YW-1:0]               oyear_q;
	logic [MW-1:0]               omonth_q;
	logic [DW-1:0]               oday_q;
	logic [gcd_pkg::WDAY_W-1:0]  owday_q;
	logic [gcd_pkg::ORD_W-1:0]   oord_q;
	logic                        oerr_q;

	logic use_yy;
	logic accept;
	logic out_load;

	logic [YW-1:0] in_year;
	logic [MW-1:0] in_month;
	logic [DW-1:0] in_day;
	logic [MW-1:0] in_month_cl;

	logic [YW-1:0] yy;
	logic [YW-1:0] div_in;
	logic [QW-1:0] div_q;
	logic          div_exact;
	logic          leap_now;

	logic [DW-1:0]        len;
	logic [DW-1:0]        prev_len;
	logic signed [WW-1:0] len_s;
	logic                 fwd;
	logic                 bwd;

	logic [SW:0]     sum_w;
	logic [PW-1:0]   m7_prod;
	logic [11:0]     m7_q;
	logic [SW:0]     m7_x7;
	logic [SW-1:0]   m7_r;
	logic [3:0]      m7_r4;
	logic [gcd_pkg::WDAY_W-1:0] wday;

	assign in_year  = s_tdata[13:0];
	assign in_month = s_tdata[17:14];
	assign in_day   = s_tdata[22:18];
	assign in_month_cl = (in_month == '0) ? gcd_pkg::MONTH_JAN :
		(in_month > gcd_pkg::MONTH_DEC) ? gcd_pkg::MONTH_DEC : in_month;

	assign accept   = s_tvalid && s_tready;
	assign out_load = (state_q == gcd_pkg::ST_WD2) && (!ovalid_q || m_tready);

	// shared divide-by-100 unit: leap tests and the weekday century terms
	assign yy     = (wm_q <= gcd_pkg::MONTH_FEB) ? wy_q - YW'(1) : wy_q;
	assign div_in = use_yy ? yy : wy_q;

	gcd_div100 u_div100 (
		.dividend (div_in),
		.quotient (div_q),
		.exact    (div_exact)
	);

	assign leap_now = (wy_q[1:0] == 2'b00) && (!div_exact || (div_q[1:0] == 2'b00));

	assign len      = gcd_pkg::month_len(wm_q, leap_q);
	assign prev_len = gcd_pkg::month_len(wm_q - MW'(1), leap_q);
	assign len_s    = signed'(WW'(len));
	assign fwd      = (wd_q > len_s);
	assign bwd      = !fwd && (wd_q < signed'(WW'(1)));

	assign sum_w = (SW+1)'(yy) + (SW+1)'(yy[YW-1:2]) - (SW+1)'(div_q)
		+ (SW+1)'(div_q[QW-1:2]) + (SW+1)'(gcd_pkg::month_term(wm_q))
		+ (SW+1)'(wd_q[DW-1:0]);

	assign m7_prod = PW'(sum_q) * PW'(gcd_pkg::MOD7_MUL);
	assign m7_q    = m7_prod[gcd_pkg::MOD7_SHIFT +: 12];
	assign m7_x7   = (SW+1)'({m7_q, 3'b000}) - (SW+1)'(m7_q);
	assign m7_r    = sum_q - m7_x7[SW-1:0];
	assign m7_r4   = m7_r[3:0];
	assign wday    = (m7_r4 >= 4'd7) ? 3'(m7_r4 - 4'd7) : m7_r4[2:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			gcd_pkg::ST_IDLE: begin
				if (accept) state_d = gcd_pkg::ST_LEAP;
			end
			gcd_pkg::ST_LEAP: state_d = gcd_pkg::ST_EXEC;
			gcd_pkg::ST_EXEC: begin
				state_d = (op_q == gcd_pkg::OP_ADD) ? gcd_pkg::ST_ADD : gcd_pkg::ST_FIN;
			end
			gcd_pkg::ST_ADD: begin
				if (fwd && wm_q == gcd_pkg::MONTH_DEC) begin
					state_d = (wy_q == gcd_pkg::YEAR_MAX) ? gcd_pkg::ST_FIN : gcd_pkg::ST_ALEAP;
				end else if (bwd && wm_q == gcd_pkg::MONTH_JAN) begin
					state_d = (wy_q == gcd_pkg::YEAR_MIN) ? gcd_pkg::ST_FIN : gcd_pkg::ST_ALEAP;
				end else if (!fwd && !bwd) begin
					state_d = gcd_pkg::ST_FIN;
				end
			end
			gcd_pkg::ST_ALEAP: state_d = gcd_pkg::ST_ADD;
			gcd_pkg::ST_FIN:   state_d = gcd_pkg::ST_FLEAP;
			gcd_pkg::ST_FLEAP: state_d = gcd_pkg::ST_WD1;
			gcd_pkg::ST_WD1:   state_d = gcd_pkg::ST_WD2;
			gcd_pkg::ST_WD2: begin
				if (out_load) state_d = gcd_pkg::ST_IDLE;
			end
			default: state_d = gcd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == gcd_pkg::ST_IDLE);
		use_yy   = (state_q == gcd_pkg::ST_WD1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= gcd_pkg::ST_IDLE;
			ovalid_q <= 1'b0;
			year_q   <= gcd_pkg::YEAR_RESET;
			month_q  <= gcd_pkg::MONTH_JAN;
			day_q    <= gcd_pkg::DAY_FIRST;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
			if (state_q == gcd_pkg::ST_FIN && !err_q) begin
				year_q  <= wy_q;
				month_q <= wm_q;
				day_q   <= wd_q[DW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			gcd_pkg::ST_IDLE: begin
				if (accept) begin
					op_q    <= gcd_pkg::op_t'(s_tuser);
					nd_q    <= in_day;
					delta_q <= signed'(s_tdata[38:23]);
					if (gcd_pkg::op_t'(s_tuser) == gcd_pkg::OP_SET) begin
						wy_q  <= in_year;
						wm_q  <= in_month_cl;
						wd_q  <= signed'(WW'(gcd_pkg::DAY_FIRST));
						err_q <= (in_year == '0) || (in_year > gcd_pkg::YEAR_MAX);
					end else begin
						wy_q  <= year_q;
						wm_q  <= month_q;
						wd_q  <= signed'(WW'(day_q));
						err_q <= 1'b0;
					end
				end
			end
			gcd_pkg::ST_LEAP, gcd_pkg::ST_ALEAP, gcd_pkg::ST_FLEAP: begin
				leap_q <= leap_now;
			end
			gcd_pkg::ST_EXEC: begin
				case (op_q)
					gcd_pkg::OP_SET: begin
						if (nd_q == '0) begin
							wd_q <= signed'(WW'(gcd_pkg::DAY_FIRST));
						end else if (nd_q > len) begin
							wd_q <= len_s;
						end else begin
							wd_q <= signed'(WW'(nd_q));
						end
					end
					gcd_pkg::OP_NEXT: begin
						if (wd_q < len_s) begin
							wd_q <= wd_q + signed'(WW'(1));
						end else begin
							wd_q <= signed'(WW'(gcd_pkg::DAY_FIRST));
							if (wm_q == gcd_pkg::MONTH_DEC) begin
								wm_q <= gcd_pkg::MONTH_JAN;
								wy_q <= wy_q + YW'(1);
								if (wy_q == gcd_pkg::YEAR_MAX) err_q <= 1'b1;
							end else begin
								wm_q <= wm_q + MW'(1);
							end
						end
					end
					gcd_pkg::OP_PREV: begin
						if (wd_q > signed'(WW'(1))) begin
							wd_q <= wd_q - signed'(WW'(1));
						end else if (wm_q == gcd_pkg::MONTH_JAN) begin
							wm_q <= gcd_pkg::MONTH_DEC;
							wy_q <= wy_q - YW'(1);
							wd_q <= signed'(WW'(gcd_pkg::DEC_LEN));
							if (wy_q == gcd_pkg::YEAR_MIN) err_q <= 1'b1;
						end else begin
							wm_q <= wm_q - MW'(1);
							wd_q <= signed'(WW'(prev_len));
						end
					end
					gcd_pkg::OP_ADD: begin
						wd_q <= wd_q + WW'(delta_q);
					end
					default: begin
						err_q <= err_q;
					end
				endcase
			end
			gcd_pkg::ST_ADD: begin
				if (fwd) begin
					wd_q <= wd_q - len_s;
					if (wm_q == gcd_pkg::MONTH_DEC) begin
						wm_q <= gcd_pkg::MONTH_JAN;
						wy_q <= wy_q + YW'(1);
						if (wy_q == gcd_pkg::YEAR_MAX) err_q <= 1'b1;
					end else begin
						wm_q <= wm_q + MW'(1);
					end
				end else if (bwd) begin
					if (wm_q == gcd_pkg::MONTH_JAN) begin
						wm_q <= gcd_pkg::MONTH_DEC;
						wy_q <= wy_q - YW'(1);
						wd_q <= wd_q + signed'(WW'(gcd_pkg::DEC_LEN));
						if (wy_q == gcd_pkg::YEAR_MIN) err_q <= 1'b1;
					end else begin
						wm_q <= wm_q - MW'(1);
						wd_q <= wd_q + signed'(WW'(prev_len));
					end
				end
			end
			gcd_pkg::ST_FIN: begin
				if (err_q) begin
					wy_q <= year_q;
					wm_q <= month_q;
					wd_q <= signed'(WW'(day_q));
				end
			end
			gcd_pkg::ST_WD1: begin
				sum_q <= sum_w[SW-1:0];
				ord_q <= gcd_pkg::cum_days(wm_q)
					+ gcd_pkg::ORD_W'((wm_q > gcd_pkg::MONTH_FEB) && leap_q)
					+ gcd_pkg::ORD_W'(wd_q[DW-1:0]);
			end
			default: begin
				leap_q <= leap_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			oyear_q  <= wy_q;
			omonth_q <= wm_q;
			oday_q   <= wd_q[DW-1:0];
			owday_q  <= wday;
			oord_q   <= ord_q;
			oerr_q   <= err_q;
		end
	end

	assign m_tvalid   = ovalid_q;
	assign m_tdata    = {5'b0, oord_q, owday_q, oday_q, omonth_q, oyear_q};
	assign m_tuser[0] = oerr_q;

	a_date_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(year_q >= gcd_pkg::YEAR_MIN) && (year_q <= gcd_pkg::YEAR_MAX)
		&& (month_q >= gcd_pkg::MONTH_JAN) && (month_q <= gcd_pkg::MONTH_DEC)
		&& (day_q != '0))
		else $error("stored date out of range");

	a_err_keeps_date: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gcd_pkg::ST_FIN) && err_q |=> $stable({year_q, month_q, day_q}))
		else $error("refused transaction changed the stored date");

	a_result_from_wd2: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == gcd_pkg::ST_WD2))
		else $error("result raised outside the final stage");

	a_result_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[25:23] != 3'd7) && (m_tdata[34:26] != '0)
		&& (m_tdata[34:26] <= 9'd366))
		else $error("weekday or ordinal day out of range");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("transaction accepted while a previous one is in work");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import gcd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned RANDOM_ITEMS = 540;
	localparam int unsigned HOLD_AT_RESULT = 120;
	localparam int unsigned HOLD_CYCLES = 300;

	// s_tdata layout, lowest field last
	typedef struct packed {
		logic                      pad;
		logic [DELTA_W-1:0]        delta;
		logic [DAY_W-1:0]          day;
		logic [MONTH_W-1:0]        month;
		logic [YEAR_W-1:0]         year;
	} date_cmd_t;

	// m_tdata layout, lowest field last
	typedef struct packed {
		logic [4:0]                pad;
		logic [ORD_W-1:0]          yday;
		logic [WDAY_W-1:0]         wday;
		logic [DAY_W-1:0]          day;
		logic [MONTH_W-1:0]        month;
		logic [YEAR_W-1:0]         year;
	} date_word_t;

	typedef struct {
		date_word_t word;
		logic       fault;
	} date_result_t;

	class calendar_tracker;
		int           cur_y;
		int           cur_m;
		int           cur_d;
		int           mismatches;
		date_result_t pending_dates[$];

		function new();
			cur_y = int'(YEAR_RESET);
			cur_m = 1;
			cur_d = 1;
			mismatches = 0;
		endfunction

		function bit is_leap_yr(int y);
			return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
		endfunction

		function int month_days(int y, int m);
			case (m)
				4, 6, 9, 11: return 30;
				2:           return is_leap_yr(y) ? 29 : 28;
				default:     return 31;
			endcase
		endfunction

		function int weekday_calc(int y, int m, int d);
			int yy;
			int mm;
			yy = y;
			mm = m;
			if (mm <= 2) begin
				yy -= 1;
				mm += 12;
			end
			return (yy + yy / 4 - yy / 100 + yy / 400 + (13 * mm + 8) / 5 + d) % 7;
		endfunction

		function int ordinal_calc(int y, int m, int d);
			int total;
			total = d;
			for (int i = 1; i < m && i <= 12; i++) begin
				total += month_days(y, i);
			end
			return total;
		endfunction

		function void apply_op(op_t op, date_cmd_t cmd);
			int           y;
			int           m;
			int           d;
			int           lim;
			int           delta;
			bit           fault;
			date_result_t res;
			y = cur_y;
			m = cur_m;
			d = cur_d;
			fault = 1'b0;
			case (op)
				OP_SET: begin
					if (cmd.year < YEAR_MIN || cmd.year > YEAR_MAX) begin
						fault = 1'b1;
					end else begin
						y = int'(cmd.year);
						m = cmd.month < 1 ? 1 : (cmd.month > 12 ? 12 : int'(cmd.month));
						lim = month_days(y, m);
						d = cmd.day < 1 ? 1 : (cmd.day > lim ? lim : int'(cmd.day));
					end
				end
				OP_NEXT: begin
					if (d < month_days(y, m)) begin
						d++;
					end else begin
						d = 1;
						m++;
						if (m > 12) begin
							m = 1;
							y++;
						end
					end
				end
				OP_PREV: begin
					if (d > 1) begin
						d--;
					end else begin
						m--;
						if (m < 1) begin
							m = 12;
							y--;
						end
						d = month_days(y, m);
					end
				end
				default: begin
					delta = $signed(cmd.delta);
					d += delta;
					while (!fault && d > month_days(y, m)) begin
						d -= month_days(y, m);
						m++;
						if (m > 12) begin
							m = 1;
							y++;
							if (y > int'(YEAR_MAX)) fault = 1'b1;
						end
					end
					while (!fault && d < 1) begin
						m--;
						if (m < 1) begin
							m = 12;
							y--;
							if (y < int'(YEAR_MIN)) begin
								fault = 1'b1;
								break;
							end
						end
						d += month_days(y, m);
					end
				end
			endcase
			if (y < int'(YEAR_MIN) || y > int'(YEAR_MAX)) fault = 1'b1;
			if (fault) begin
				y = cur_y;
				m = cur_m;
				d = cur_d;
			end else begin
				cur_y = y;
				cur_m = m;
				cur_d = d;
			end
			res.word = '0;
			res.word.year = y[YEAR_W-1:0];
			res.word.month = m[MONTH_W-1:0];
			res.word.day = d[DAY_W-1:0];
			res.word.wday = WDAY_W'(weekday_calc(y, m, d));
			res.word.yday = ORD_W'(ordinal_calc(y, m, d));
			res.fault = fault;
			pending_dates.push_back(res);
		endfunction

		function void field_check(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void compare_result(date_word_t got, logic got_fault);
			date_result_t want;
			if (pending_dates.size() == 0) begin
				$display("%0t: unexpected transaction, expected none actual %h/%b",
					$time, got, got_fault);
				mismatches++;
				return;
			end
			want = pending_dates.pop_front();
			field_check("cur_year", want.word.year, got.year);
			field_check("cur_month", want.word.month, got.month);
			field_check("cur_day", want.word.day, got.day);
			field_check("weekday", want.word.wday, got.wday);
			field_check("ordinal_day", want.word.yday, got.yday);
			field_check("range_error", want.fault, got_fault);
		endfunction

		function int outstanding();
			return pending_dates.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [0:0]  m_tuser;

	calendar_tracker tracker = new();
	bit              burst = 1'b0;
	int unsigned     cycle_count = 0;

	gregorian_calendar_date_unit_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[gregorian_calendar_date_unit_top] ERROR");
			$finish;
		end
	end

	task automatic offer(op_t op, int ny, int nm, int nd, int dl);
		date_cmd_t   cmd;
		int unsigned gap;
		cmd = '0;
		cmd.year = ny[YEAR_W-1:0];
		cmd.month = nm[MONTH_W-1:0];
		cmd.day = nd[DAY_W-1:0];
		cmd.delta = dl[DELTA_W-1:0];
		gap = burst ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= cmd;
		s_tuser <= op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.apply_op(op, cmd);
	endtask

	task automatic wait_drained();
		while (tracker.outstanding() != 0) @(posedge clk);
	endtask

	task automatic random_item();
		op_t op;
		int  ny;
		int  dl;
		int  pick;
		pick = $urandom_range(0, 99);
		op = pick < 25 ? OP_SET : (pick < 45 ? OP_NEXT : (pick < 65 ? OP_PREV : OP_ADD));
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			ny = $urandom_range(0, 16383);
		end else if (pick < 3) begin
			ny = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(9997, 9999);
		end else begin
			ny = $urandom_range(1, 9999);
		end
		pick = $urandom_range(0, 9);
		if (pick < 5) begin
			dl = int'($urandom_range(0, 800)) - 400;
		end else if (pick < 8) begin
			dl = int'($urandom_range(0, 10000)) - 5000;
		end else begin
			dl = $urandom_range(0, 65535);
		end
		offer(op, ny, $urandom_range(0, 15), $urandom_range(0, 31), dl);
	endtask

	// result side: random stalls, one long hold-off to back up the input
	initial begin
		int unsigned stall;
		int unsigned results_seen;
		results_seen = 0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = burst ? 0 : $urandom_range(0, 17);
			if (results_seen == HOLD_AT_RESULT) stall = HOLD_CYCLES;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			tracker.compare_result(date_word_t'(m_tdata), m_tuser[0]);
			results_seen++;
		end
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= OP_SET;
		m_tready <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: limits, clamping, leap rules, refused moves
		offer(OP_NEXT, $urandom_range(0, 16383), 15, 31, 32767);
		offer(OP_SET, 0, 6, 15, 0);
		offer(OP_SET, 16383, 15, 31, -1);
		offer(OP_SET, 10000, 1, 1, 0);
		offer(OP_SET, 9999, 15, 31, 0);
		offer(OP_NEXT, 0, 0, 0, 0);
		offer(OP_PREV, 0, 0, 0, 0);
		offer(OP_SET, 1, 0, 0, 0);
		offer(OP_PREV, 16383, 15, 31, -1);
		offer(OP_ADD, 0, 0, 0, -1);
		offer(OP_NEXT, 0, 0, 0, 0);
		offer(OP_SET, 2000, 2, 31, 0);
		offer(OP_NEXT, 0, 0, 0, 0);
		offer(OP_PREV, 0, 0, 0, 0);
		offer(OP_SET, 1900, 2, 30, 0);
		offer(OP_NEXT, 0, 0, 0, 0);
		offer(OP_SET, 2023, 4, 31, 0);
		offer(OP_SET, 2024, 3, 1, 0);
		offer(OP_PREV, 0, 0, 0, 0);
		offer(OP_ADD, 0, 0, 0, 32767);
		offer(OP_ADD, 0, 0, 0, -32768);
		offer(OP_SET, 2023, 12, 31, 0);
		offer(OP_ADD, 0, 0, 0, 1);
		offer(OP_ADD, 0, 0, 0, 0);
		offer(OP_SET, 9990, 6, 15, 0);
		offer(OP_ADD, 0, 0, 0, 32767);
		offer(OP_SET, 5, 6, 15, 0);
		offer(OP_ADD, 0, 0, 0, -32768);

		s_tvalid <= 1'b0;
		@(posedge clk);
		wait_drained();
		@(posedge clk);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			burst = (i >= 180 && i < 240);
			if (i == 400) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				wait_drained();
				@(posedge clk);
			end
			random_item();
		end
		burst = 1'b0;
		s_tvalid <= 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0) begin
			$display("[gregorian_calendar_date_unit_top] OK");
		end else begin
			$display("[gregorian_calendar_date_unit_top] ERROR");
		end
		$finish;
	end

endmodule
